// ===== hdl/bmbt_pkg.sv =====
// Shared types, constants and helper functions for the bit matrix block transpose.
package bmbt_pkg;

   // Fixed field widths
   localparam int ROW_W      = 64;
   localparam int CNT_W      = 7;
   localparam int ROW_IDX_W  = 6;
   localparam int CSR_ADDR_W = 1;

   // Default block size in bits
   localparam int DEF_BLOCK_BITS = 64;

   // Register reset value of both row counts
   localparam logic [CNT_W-1:0] ROWS_RESET = 7'd64;

   // Register indexes on the write port
   localparam logic [CSR_ADDR_W-1:0] CSR_IN_ROWS  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_ROWS = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PREP,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                 wr_en;
      logic [ROW_IDX_W-1:0] wr_idx;
      logic                 step;
      logic [CNT_W-1:0]     step_idx;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [CNT_W-1:0] nin;
      logic [CNT_W-1:0] nout;
   } dp_status_type;

   // Largest power of two from 4 to 64 that does not exceed the requested size, or 4 for a smaller size
   function automatic int blk_size(input int bits);
      int b;
      b = 4;
      for (int s = 0; s < 4; s++) begin
         if (b * 2 <= bits) begin
            b = b * 2;
         end
      end
      return b;
   endfunction

   // Ones in the bits that the block covers
   function automatic logic [ROW_W-1:0] low_mask(input int blk);
      logic [ROW_W-1:0] m;
      m = '0;
      for (int i = 0; i < ROW_W; i++) begin
         m[i] = (i < blk);
      end
      return m;
   endfunction

   // Row count as used: zero works as one, above the block works as the block
   function automatic logic [CNT_W-1:0] clamp_rows(input logic [CNT_W-1:0] v, input int blk);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CNT_W'(blk)) begin
         r = CNT_W'(blk);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hdl/bit_matrix_block_transpose.sv =====
// Top level of the bit matrix block transpose.
//
// Transposes one B by B block of a bit matrix, B being the largest power of
// two from 4 to 64 not above BLOCK_BITS. Source rows arrive one per cycle on
// the req_ channel while req_tready is high and are stored in a shifting
// flip-flop matrix; once in_rows rows have arrived, a setup state loads the
// first column into the output register, then out_rows column words leave on
// the rsp_ channel at one word per cycle while rsp_tready stays high, the last
// flagged by rsp_tlast. The single matrix holds one block, so requests are not
// taken during emission. Row counts of zero act as one and values above B act
// as B; the user must write them through the csr_ port only while the block
// is idle, which the block itself does not enforce.
module bit_matrix_block_transpose #(
   parameter int BLOCK_BITS = bmbt_pkg::DEF_BLOCK_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // Source rows
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bmbt_pkg::ROW_W-1:0]       req_tdata,   // [63:0] row_word
   // Transposed words
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bmbt_pkg::ROW_W-1:0]       rsp_tdata,   // [63:0] col_word
   output logic                             rsp_tlast,
   // Register writes
   input  logic                             csr_we,
   input  logic [bmbt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bmbt_pkg::CNT_W-1:0]       csr_wdata
);

   bmbt_pkg::dp_cmd_type    cmd;
   bmbt_pkg::dp_status_type status;

   bmbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   bmbt_datapath #(
      .BLOCK_BITS (BLOCK_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .row_word  (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .col_word  (rsp_tdata)
   );

endmodule

// ===== hdl/bmbt_datapath.sv =====
// Datapath: row counts, shifting bit matrix and output word register.
module bmbt_datapath #(
   parameter int BLOCK_BITS = bmbt_pkg::DEF_BLOCK_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bmbt_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [bmbt_pkg::CNT_W-1:0]        csr_wdata,
   input  logic [bmbt_pkg::ROW_W-1:0]        row_word,
   input  bmbt_pkg::dp_cmd_type              cmd,
   output bmbt_pkg::dp_status_type           status,
   output logic [bmbt_pkg::ROW_W-1:0]        col_word
);

   localparam int BLK = bmbt_pkg::blk_size(BLOCK_BITS);
   localparam logic [bmbt_pkg::ROW_W-1:0] LOW_MASK = bmbt_pkg::low_mask(BLK);

   logic [bmbt_pkg::CNT_W-1:0] in_rows_ff;
   logic [bmbt_pkg::CNT_W-1:0] out_rows_ff;
   logic [bmbt_pkg::CNT_W-1:0] nin;
   logic [bmbt_pkg::ROW_W-1:0] row_ff [BLK];
   logic [bmbt_pkg::ROW_W-1:0] row_in [BLK];
   logic [bmbt_pkg::ROW_W-1:0] shift_w [BLK];
   logic [bmbt_pkg::ROW_W-1:0] col_ff;
   logic [bmbt_pkg::ROW_W-1:0] col_in;

   // Row count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_rows_ff  <= bmbt_pkg::ROWS_RESET;
         out_rows_ff <= bmbt_pkg::ROWS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            bmbt_pkg::CSR_IN_ROWS:  in_rows_ff  <= csr_wdata;
            bmbt_pkg::CSR_OUT_ROWS: out_rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nin         = bmbt_pkg::clamp_rows(in_rows_ff, BLK);
   assign status.nin  = nin;
   assign status.nout = bmbt_pkg::clamp_rows(out_rows_ff, BLK);

   // Per row: block bits move one place towards bit 0, bits above the
   // block move down one row towards row 0, so bit 0 of each row shows the next column
   for (genvar g = 0; g < BLK; g++) begin : g_row
      if (g + 1 < BLK) begin : g_mid
         assign shift_w[g] = ((row_ff[g] >> 1) & LOW_MASK) | (row_ff[g+1] & ~LOW_MASK);
      end else begin : g_top
         assign shift_w[g] = (row_ff[g] >> 1) & LOW_MASK;
      end
      assign row_in[g] = cmd.step ? shift_w[g] :
                         (cmd.wr_en && cmd.wr_idx == bmbt_pkg::ROW_IDX_W'(g)) ? row_word :
                         row_ff[g];
   end

   // Matrix store, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < BLK; i++) begin
         row_ff[i] <= row_in[i];
      end
   end

   // Next column: bit 0 of each row below in_rows, plus the upper bits of the current row
   always_comb begin
      col_in = '0;
      for (int i = 0; i < BLK; i++) begin
         col_in[i] = row_ff[i][0] & (bmbt_pkg::CNT_W'(i) < nin);
      end
      if (cmd.step_idx < nin) begin
         col_in = col_in | (row_ff[0] & ~LOW_MASK);
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         col_ff <= col_in;
      end
   end

   assign col_word = col_ff;

endmodule

// ===== hdl/bmbt_ctrl.sv =====
// Controller: row loading count, emission count and the response handshake.
module bmbt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic                     rsp_tlast,
   input  bmbt_pkg::dp_status_type  status,
   output bmbt_pkg::dp_cmd_type     cmd
);

   bmbt_pkg::state_type        state_ff;
   bmbt_pkg::state_type        state_in;
   logic [bmbt_pkg::CNT_W-1:0] rows_loaded_ff;
   logic [bmbt_pkg::CNT_W-1:0] rows_loaded_in;
   logic [bmbt_pkg::CNT_W-1:0] emit_k_ff;
   logic [bmbt_pkg::CNT_W-1:0] emit_k_in;
   logic                       valid_ff;
   logic                       valid_in;
   logic                       last_ff;
   logic                       last_in;
   logic                       req_take;
   logic                       rsp_take;
   logic                       block_done;

   assign req_take   = req_tvalid && (state_ff == bmbt_pkg::ST_LOAD);
   assign rsp_take   = valid_ff && rsp_tready;
   assign block_done = (rows_loaded_ff + bmbt_pkg::CNT_W'(1)) >= status.nin;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmbt_pkg::ST_LOAD: if (req_take && block_done) state_in = bmbt_pkg::ST_PREP;
         bmbt_pkg::ST_PREP: state_in = bmbt_pkg::ST_EMIT;
         bmbt_pkg::ST_EMIT: if (rsp_take && last_ff) state_in = bmbt_pkg::ST_LOAD;
         default:           state_in = bmbt_pkg::ST_LOAD;
      endcase
   end

   // Commands and counters
   always_comb begin
      cmd            = '0;
      rows_loaded_in = rows_loaded_ff;
      emit_k_in      = emit_k_ff;
      valid_in       = valid_ff;
      last_in        = last_ff;
      unique case (state_ff)
         bmbt_pkg::ST_LOAD: begin
            if (req_take) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_idx = rows_loaded_ff[bmbt_pkg::ROW_IDX_W-1:0];
               rows_loaded_in = block_done ? '0 : rows_loaded_ff + bmbt_pkg::CNT_W'(1);
            end
         end
         bmbt_pkg::ST_PREP: begin
            // First column into the output register
            cmd.step     = 1'b1;
            cmd.step_idx = '0;
            valid_in     = 1'b1;
            last_in      = (status.nout == bmbt_pkg::CNT_W'(1));
            emit_k_in    = bmbt_pkg::CNT_W'(1);
         end
         bmbt_pkg::ST_EMIT: begin
            if (rsp_take) begin
               if (last_ff) begin
                  valid_in = 1'b0;
                  last_in  = 1'b0;
               end else begin
                  cmd.step     = 1'b1;
                  cmd.step_idx = emit_k_ff;
                  last_in      = (emit_k_ff + bmbt_pkg::CNT_W'(1)) == status.nout;
                  emit_k_in    = emit_k_ff + bmbt_pkg::CNT_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bmbt_pkg::ST_LOAD;
         rows_loaded_ff <= '0;
         emit_k_ff      <= '0;
         valid_ff       <= 1'b0;
         last_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rows_loaded_ff <= rows_loaded_in;
         emit_k_ff      <= emit_k_in;
         valid_ff       <= valid_in;
         last_ff        <= last_in;
      end
   end

   assign req_tready = (state_ff == bmbt_pkg::ST_LOAD);
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   // Loading and emission never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a response is pending");

   // Last word taken returns the block to loading
   a_last_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("block did not return to loading after its last word");

   // The setup state is always followed by a valid word
   a_prep_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmbt_pkg::ST_PREP) |=> rsp_tvalid)
      else $error("no response after block setup");

   // A completed block stops further requests at once
   a_block_stop: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && block_done) |=> (!req_tready && rows_loaded_ff == '0))
      else $error("loading continued after the last row of a block");
`endif

endmodule
